/* hdl/bpeg_pkg.sv */
// Shared constants and types for the block peak envelope gate.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bpeg_pkg;

   // Default widths
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEFF_BITS_DEF  = 16;
   localparam int TRACK_BITS      = 16;

   // Register indexes on the CSR port
   localparam int CSR_INDEX_BITS   = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GATE_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK_COEFF   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_COEFF  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_TRACK   = 2'd3;

   // Reset threshold is 838861 in Q1.23 (about 0.1), rescaled to the level width
   localparam longint THRESH_RESET_Q23 = 838861;
   localparam int     THRESH_REF_BITS  = 24;
   localparam logic [TRACK_BITS-1:0] TRACK_RESET = '1;

   // Peak queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

/* hdl/bpeg_front.sv */
// Front end: accepts samples, tracks the running block peak, queues it at block end.
// Depends on bpeg_pkg (queue status struct).
`timescale 1ns / 1ps

module bpeg_front #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_block_end,
   input  bpeg_pkg::q_status_type        q_status,
   output logic                          push,
   output logic [SAMPLE_BITS-1:0]        push_peak
);
   import bpeg_pkg::*;

   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SAMPLE_BITS-1:0] peak_now;
   logic                   accept;

   // stall only while the queue has no room
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // magnitude; the most negative sample maps to 2^(N-1), which still fits
   assign raw      = $unsigned(req_sample);
   assign mag      = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
   assign peak_now = (mag > peak_ff) ? mag : peak_ff;

   assign push      = accept && req_block_end;
   assign push_peak = peak_now;

   // running peak, cleared once the block is queued
   always_comb begin
      peak_in = peak_ff;
      if (accept) begin
         peak_in = req_block_end ? '0 : peak_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else begin
         peak_ff <= peak_in;
      end
   end

endmodule

/* hdl/bpeg_queue.sv */
// Short FIFO of finished block peaks between front and back.
// Depends on bpeg_pkg (depth constants, status struct).
`timescale 1ns / 1ps

module bpeg_queue #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [SAMPLE_BITS-1:0] push_peak,
   input  logic                   pop,
   output logic [SAMPLE_BITS-1:0] head_peak,
   output bpeg_pkg::q_status_type q_status
);
   import bpeg_pkg::*;

   logic [SAMPLE_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign q_status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_peak      = entry_ff[rd_ptr_ff];

   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_peak;
      end
   end

endmodule

/* hdl/bpeg_back.sv */
// Back end: envelope update, gate decision and the result register.
// Depends on bpeg_pkg (track width, queue status struct).
`timescale 1ns / 1ps

module bpeg_back #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEFF_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bpeg_pkg::q_status_type          q_status,
   input  logic [SAMPLE_BITS-1:0]          head_peak,
   output logic                            pop,
   input  logic [SAMPLE_BITS-1:0]          gate_threshold,
   input  logic [COEFF_BITS-1:0]           attack_coeff,
   input  logic [COEFF_BITS-1:0]           release_coeff,
   input  logic [bpeg_pkg::TRACK_BITS-1:0] source_track,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [SAMPLE_BITS-1:0]          rsp_peak_level,
   output logic [SAMPLE_BITS-1:0]          rsp_envelope_level,
   output logic                            rsp_gate_state,
   output logic                            rsp_gate_opened,
   output logic                            rsp_gate_closed,
   output logic [bpeg_pkg::TRACK_BITS-1:0] rsp_event_track
);
   import bpeg_pkg::*;

   localparam int ProdBits = SAMPLE_BITS + COEFF_BITS + 2;

   // envelope stage
   logic                   env_valid_ff, env_valid_in;
   logic [SAMPLE_BITS-1:0] env_peak_ff;
   logic [SAMPLE_BITS-1:0] env_ff, env_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_peak_ff, rsp_env_ff;
   logic                   rsp_gate_ff, rsp_opened_ff, rsp_closed_ff;
   logic [TRACK_BITS-1:0]  rsp_track_ff;
   logic                   gate_ff, gate_in;

   logic                        out_free;
   logic                        advance;
   logic [COEFF_BITS-1:0]       coeff;
   logic signed [SAMPLE_BITS:0] diff;
   logic signed [ProdBits-1:0]  prod;
   logic signed [ProdBits-1:0]  delta;
   logic signed [ProdBits-1:0]  env_next;
   logic                        opening, closing;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = env_valid_ff && out_free;
   assign pop      = !q_status.empty && (!env_valid_ff || out_free);

   // one-pole update: env + floor(coeff * (peak - env) / 2^COEFF_BITS)
   assign coeff    = (head_peak > env_ff) ? attack_coeff : release_coeff;
   assign diff     = $signed({1'b0, head_peak}) - $signed({1'b0, env_ff});
   assign prod     = diff * $signed({1'b0, coeff});
   assign delta    = prod >>> COEFF_BITS;
   assign env_next = $signed({{(COEFF_BITS + 2){1'b0}}, env_ff}) + delta;

   always_comb begin
      env_in       = env_ff;
      env_valid_in = env_valid_ff;
      if (pop) begin
         env_in       = env_next[ProdBits-1] ? '0 : env_next[SAMPLE_BITS-1:0];
         env_valid_in = 1'b1;
      end else if (out_free) begin
         env_valid_in = 1'b0;
      end
   end

   // gate with strict compares; equal keeps the state
   assign opening = !gate_ff && (env_ff > gate_threshold);
   assign closing = gate_ff && (env_ff < gate_threshold);

   always_comb begin
      gate_in      = gate_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         gate_in      = opening ? 1'b1 : (closing ? 1'b0 : gate_ff);
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_valid_ff <= 1'b0;
         env_ff       <= '0;
         gate_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         env_valid_ff <= env_valid_in;
         env_ff       <= env_in;
         gate_ff      <= gate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         env_peak_ff <= head_peak;
      end
      if (advance) begin
         rsp_peak_ff   <= env_peak_ff;
         rsp_env_ff    <= env_ff;
         rsp_gate_ff   <= gate_in;
         rsp_opened_ff <= opening;
         rsp_closed_ff <= closing;
         rsp_track_ff  <= source_track;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_peak_level     = rsp_peak_ff;
   assign rsp_envelope_level = rsp_env_ff;
   assign rsp_gate_state     = rsp_gate_ff;
   assign rsp_gate_opened    = rsp_opened_ff;
   assign rsp_gate_closed    = rsp_closed_ff;
   assign rsp_event_track    = rsp_track_ff;

endmodule

/* hdl/block_peak_envelope_gate_core.sv */
// Top level of the block peak envelope gate: CSRs, front, peak queue and back.
// Depends on bpeg_pkg, bpeg_front, bpeg_queue and bpeg_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   req     | in        | req_valid/req_stall  | req_sample, req_block_end
//   rsp     | out       | rsp_valid/rsp_stall  | peak, envelope, gate state/events, track
//   csr     | in        | csr_we               | csr_index, csr_data
//
// One sample is taken every cycle while req_stall is low; after its last sample, a block
// result passes the queue, envelope multiply stage, gate and result register in turn.
// The envelope loop closes around one multiply per cycle, so blocks as short as
// one sample still sustain one transaction per cycle while rsp_stall stays low.
// Synchronous active-high reset clears peak, envelope, gate and queue and loads
// CSR defaults. A held rsp_stall fills the four-entry peak queue, then req_stall rises.
`timescale 1ns / 1ps

module block_peak_envelope_gate_core #(
   parameter int SAMPLE_BITS = bpeg_pkg::SAMPLE_BITS_DEF,
   parameter int COEFF_BITS  = bpeg_pkg::COEFF_BITS_DEF,
   localparam int CsrBits    = (SAMPLE_BITS > COEFF_BITS)
                               ? ((SAMPLE_BITS > bpeg_pkg::TRACK_BITS)
                                  ? SAMPLE_BITS : bpeg_pkg::TRACK_BITS)
                               : ((COEFF_BITS > bpeg_pkg::TRACK_BITS)
                                  ? COEFF_BITS : bpeg_pkg::TRACK_BITS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic                                req_block_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [SAMPLE_BITS-1:0]              rsp_peak_level,
   output logic [SAMPLE_BITS-1:0]              rsp_envelope_level,
   output logic                                rsp_gate_state,
   output logic                                rsp_gate_opened,
   output logic                                rsp_gate_closed,
   output logic [bpeg_pkg::TRACK_BITS-1:0]     rsp_event_track,
   input  logic                                csr_we,
   input  logic [bpeg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CsrBits-1:0]                  csr_data
);
   import bpeg_pkg::*;

   localparam logic [SAMPLE_BITS-1:0] ThreshReset =
      SAMPLE_BITS'((THRESH_RESET_Q23 << SAMPLE_BITS) >> THRESH_REF_BITS);
   localparam logic [COEFF_BITS-1:0] AttackReset  = COEFF_BITS'(1) << (COEFF_BITS - 1);
   localparam logic [COEFF_BITS-1:0] ReleaseReset = COEFF_BITS'(1) << (COEFF_BITS - 4);

   logic [SAMPLE_BITS-1:0] threshold_ff;
   logic [COEFF_BITS-1:0]  attack_ff;
   logic [COEFF_BITS-1:0]  release_ff;
   logic [TRACK_BITS-1:0]  track_ff;

   logic                   push;
   logic [SAMPLE_BITS-1:0] push_peak;
   logic                   pop;
   logic [SAMPLE_BITS-1:0] head_peak;
   q_status_type           q_status;

   // configuration registers; unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ThreshReset;
         attack_ff    <= AttackReset;
         release_ff   <= ReleaseReset;
         track_ff     <= TRACK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GATE_THRESHOLD: threshold_ff <= csr_data[SAMPLE_BITS-1:0];
            CSR_ATTACK_COEFF:   attack_ff    <= csr_data[COEFF_BITS-1:0];
            CSR_RELEASE_COEFF:  release_ff   <= csr_data[COEFF_BITS-1:0];
            CSR_SOURCE_TRACK:   track_ff     <= csr_data[TRACK_BITS-1:0];
            default: ;
         endcase
      end
   end

   bpeg_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .req_block_end(req_block_end),
      .q_status     (q_status),
      .push         (push),
      .push_peak    (push_peak)
   );

   bpeg_queue #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_peak(push_peak),
      .pop      (pop),
      .head_peak(head_peak),
      .q_status (q_status)
   );

   bpeg_back #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEFF_BITS (COEFF_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .head_peak         (head_peak),
      .pop               (pop),
      .gate_threshold    (threshold_ff),
      .attack_coeff      (attack_ff),
      .release_coeff     (release_ff),
      .source_track      (track_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_peak_level    (rsp_peak_level),
      .rsp_envelope_level(rsp_envelope_level),
      .rsp_gate_state    (rsp_gate_state),
      .rsp_gate_opened   (rsp_gate_opened),
      .rsp_gate_closed   (rsp_gate_closed),
      .rsp_event_track   (rsp_event_track)
   );

endmodule
